[rtl/rlbe_pkg.sv]
package rlbe_pkg;

    // Result codes on the output channel
    typedef enum logic [1:0] {
        CODE_ZERO  = 2'd0,
        CODE_ONE   = 2'd1,
        CODE_BREAK = 2'd2
    } code_t;

    // Register map, selected by paddr[2]
    localparam logic REG_ROW_WIDTH   = 1'b0;
    localparam logic REG_START_COLOR = 1'b1;

    localparam int ROW_W  = 5;   // row_width register width
    localparam int COL_W  = 4;   // column counter width
    localparam int ADDR_W = 3;   // APB address width
    localparam int DATA_W = 32;  // APB data width

    localparam logic [ROW_W-1:0] ROW_MIN = 5'd1;
    localparam logic [ROW_W-1:0] ROW_MAX = 5'd16;
    localparam logic [ROW_W-1:0] ROW_RST = 5'd9;
    localparam logic             COLOR_RST = 1'b1;

    // Expander sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PIXEL,
        BK_BREAK
    } bk_state_t;

endpackage

[rtl/rlbe_run_if.sv]
interface rlbe_run_if #(
    parameter int RUN_BITS = 4
);
    logic                valid;
    logic                ready;
    logic [RUN_BITS-1:0] run_length;

    modport source (output valid, output run_length, input ready);
    modport sink   (input valid, input run_length, output ready);
endinterface

[rtl/rlbe_res_if.sv]
interface rlbe_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_code;
    logic       last_of_run;

    modport source (output valid, output out_code, output last_of_run, input ready);
    modport sink   (input valid, input out_code, input last_of_run, output ready);
endinterface

[rtl/rlbe_front.sv]
module rlbe_front #(
    parameter int RUN_BITS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rlbe_run_if.sink                      run_in,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rlbe_pkg::ADDR_W-1:0]   paddr,
    input  logic [rlbe_pkg::DATA_W-1:0]   pwdata,
    output logic [rlbe_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic                          q_push,
    output logic [RUN_BITS:0]             q_data,
    input  logic                          q_ready,
    output logic [rlbe_pkg::ROW_W-1:0]    eff_width
);

    logic [rlbe_pkg::ROW_W-1:0] row_width_reg;
    logic [rlbe_pkg::ROW_W-1:0] row_width_next;
    logic                       start_color_reg;
    logic                       start_color_next;
    logic                       color_reg;
    logic                       color_next;
    logic                       cfg_wr;
    logic                       run_xfer;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign run_xfer = run_in.valid && run_in.ready;

    // Zero-length runs only flip the color; others go to the queue
    assign run_in.ready = q_ready;
    assign q_push       = run_xfer && (run_in.run_length != '0);
    assign q_data       = {color_reg, run_in.run_length};

    // Register writes and color tracking
    always_comb
    begin
        row_width_next   = row_width_reg;
        start_color_next = start_color_reg;
        color_next       = color_reg;
        if (run_xfer)
        begin
            color_next = ~color_reg;
        end
        if (cfg_wr)
        begin
            unique case (paddr[2])
                rlbe_pkg::REG_ROW_WIDTH:
                begin
                    row_width_next = pwdata[rlbe_pkg::ROW_W-1:0];
                end
                rlbe_pkg::REG_START_COLOR:
                begin
                    start_color_next = pwdata[0];
                    color_next       = pwdata[0];
                end
                default:
                begin
                    row_width_next = row_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg   <= rlbe_pkg::ROW_RST;
            start_color_reg <= rlbe_pkg::COLOR_RST;
            color_reg       <= rlbe_pkg::COLOR_RST;
        end
        else
        begin
            row_width_reg   <= row_width_next;
            start_color_reg <= start_color_next;
            color_reg       <= color_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            rlbe_pkg::REG_ROW_WIDTH:
                prdata = {{(rlbe_pkg::DATA_W-rlbe_pkg::ROW_W){1'b0}}, row_width_reg};
            rlbe_pkg::REG_START_COLOR:
                prdata = {{(rlbe_pkg::DATA_W-1){1'b0}}, start_color_reg};
            default:
                prdata = '0;
        endcase
    end

    // Clamp width into 1..16
    always_comb
    begin
        priority if (row_width_reg == '0)
            eff_width = rlbe_pkg::ROW_MIN;
        else if (row_width_reg > rlbe_pkg::ROW_MAX)
            eff_width = rlbe_pkg::ROW_MAX;
        else
            eff_width = row_width_reg;
    end

endmodule

[rtl/rlbe_queue.sv]
module rlbe_queue #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 2   // power of two
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             not_full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign not_full  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign rdata     = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");
`endif

endmodule

[rtl/rlbe_back.sv]
module rlbe_back #(
    parameter int RUN_BITS = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  logic [RUN_BITS:0]          q_data,
    output logic                       q_pop,
    input  logic [rlbe_pkg::ROW_W-1:0] eff_width,
    rlbe_res_if.source                 res_out
);

    rlbe_pkg::bk_state_t          state_reg;
    rlbe_pkg::bk_state_t          state_next;
    logic [RUN_BITS-1:0]          rem_reg;
    logic [RUN_BITS-1:0]          rem_next;
    logic                         color_reg;
    logic                         color_next;
    logic [rlbe_pkg::COL_W-1:0]   col_reg;
    logic [rlbe_pkg::COL_W-1:0]   col_next;
    logic                         ovalid_reg;
    logic                         ovalid_next;
    rlbe_pkg::code_t              ocode_reg;
    rlbe_pkg::code_t              ocode_next;
    logic                         olast_reg;
    logic                         olast_next;
    logic                         emit;
    logic                         wrap;

    // A result can be produced when the output register is free or draining
    assign emit = (state_reg != rlbe_pkg::BK_IDLE) && (!ovalid_reg || res_out.ready);
    assign wrap = ({1'b0, col_reg} + 1'b1) >= eff_width;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rlbe_pkg::BK_IDLE:
            begin
                if (q_valid)
                    state_next = rlbe_pkg::BK_PIXEL;
            end
            rlbe_pkg::BK_PIXEL:
            begin
                if (emit)
                begin
                    if (wrap)
                        state_next = rlbe_pkg::BK_BREAK;
                    else if (rem_reg == RUN_BITS'(1))
                        state_next = rlbe_pkg::BK_IDLE;
                end
            end
            rlbe_pkg::BK_BREAK:
            begin
                if (emit)
                    state_next = (rem_reg == '0) ? rlbe_pkg::BK_IDLE : rlbe_pkg::BK_PIXEL;
            end
            default:
                state_next = rlbe_pkg::BK_IDLE;
        endcase
    end

    // Datapath and output register updates
    always_comb
    begin
        q_pop       = 1'b0;
        rem_next    = rem_reg;
        color_next  = color_reg;
        col_next    = col_reg;
        ocode_next  = ocode_reg;
        olast_next  = olast_reg;
        ovalid_next = res_out.ready ? 1'b0 : ovalid_reg;
        unique case (state_reg)
            rlbe_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rem_next   = q_data[RUN_BITS-1:0];
                    color_next = q_data[RUN_BITS];
                end
            end
            rlbe_pkg::BK_PIXEL:
            begin
                if (emit)
                begin
                    rem_next    = RUN_BITS'(rem_reg - 1'b1);
                    col_next    = wrap ? '0 : rlbe_pkg::COL_W'(col_reg + 1'b1);
                    ovalid_next = 1'b1;
                    ocode_next  = color_reg ? rlbe_pkg::CODE_ONE : rlbe_pkg::CODE_ZERO;
                    olast_next  = (rem_reg == RUN_BITS'(1)) && !wrap;
                end
            end
            rlbe_pkg::BK_BREAK:
            begin
                if (emit)
                begin
                    ovalid_next = 1'b1;
                    ocode_next  = rlbe_pkg::CODE_BREAK;
                    olast_next  = (rem_reg == '0);
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rlbe_pkg::BK_IDLE;
            col_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        color_reg <= color_next;
        ocode_reg <= ocode_next;
        olast_reg <= olast_next;
    end

    assign res_out.valid       = ovalid_reg;
    assign res_out.out_code    = ocode_reg;
    assign res_out.last_of_run = olast_reg;

`ifndef SYNTHESIS
    a_break_col: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlbe_pkg::BK_BREAK) |-> (col_reg == '0))
        else $error("line break pending with nonzero column");
    a_pixel_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlbe_pkg::BK_PIXEL) |-> (rem_reg != '0))
        else $error("pixel state with no pixels left");
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlbe_pkg::BK_IDLE) && ovalid_reg |-> olast_reg)
        else $error("idle while a mid-run result is pending");
`endif

endmodule

[rtl/run_length_bitmap_expander_top.sv]
// Path: a run is queued, loaded by the expander when idle; results are registered.
// Throughput: one result per cycle while the receiver is ready; a nonzero run of
//   L pixels with B line breaks yields L + B results after a load step in the
//   idle state; zero-length runs only flip the color and never reach the expander.
// Reset: row_width 9, start color 1, column 0, queue and output register empty.
module run_length_bitmap_expander_top #(
    parameter int RUN_BITS    = 4,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rlbe_run_if.sink                      run_in,
    rlbe_res_if.source                    res_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rlbe_pkg::ADDR_W-1:0]   paddr,
    input  logic [rlbe_pkg::DATA_W-1:0]   pwdata,
    output logic [rlbe_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic                       q_push;
    logic [RUN_BITS:0]          q_wdata;
    logic                       q_not_full;
    logic                       q_pop;
    logic [RUN_BITS:0]          q_rdata;
    logic                       q_not_empty;
    logic [rlbe_pkg::ROW_W-1:0] eff_width;

    rlbe_front #(
        .RUN_BITS (RUN_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_in    (run_in),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .q_push    (q_push),
        .q_data    (q_wdata),
        .q_ready   (q_not_full),
        .eff_width (eff_width)
    );

    rlbe_queue #(
        .WIDTH (RUN_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty)
    );

    rlbe_back #(
        .RUN_BITS (RUN_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .eff_width (eff_width),
        .res_out   (res_out)
    );

endmodule

[test/tb_top.sv]
module tb_top;

    import rlbe_pkg::*;

    // One expanded result as the expander should produce it
    typedef struct packed {
        code_t code;
        logic  last;
    } px_result_t;

    localparam int MAX_WAIT      = 14;    // longest per-transfer idle draw
    localparam int SETTLE_CYCLES = 20;    // quiet time before touching registers
    localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
    localparam int STUCK_LIMIT   = 2000;  // cycles without any transfer

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    rlbe_run_if #(.RUN_BITS(4)) run_ch ();
    rlbe_res_if                 res_ch ();

    run_length_bitmap_expander_top #(
        .RUN_BITS(4)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .run_in  (run_ch),
        .res_out (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Expander model state and register shadow
    logic [ROW_W-1:0] row_width_cfg;
    logic             start_color_cfg;
    logic             color_now;
    int               col_now;

    px_result_t pending_pixels[$];

    // Traffic shaping knobs
    bit tx_gap_on;
    bit rx_stall_on;
    int hold_len;

    // Bookkeeping
    int fail_count;
    int runs_sent;
    int zero_runs;
    int results_seen;
    int breaks_seen;
    int reg_writes;
    int stuck_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Expand one run into pixel and line-break codes
    function automatic void expand_run(input logic [3:0] len);
        int width;
        int k;
        px_result_t r;
        width = row_width_cfg;
        if (row_width_cfg < ROW_MIN)
            width = ROW_MIN;
        if (row_width_cfg > ROW_MAX)
            width = ROW_MAX;
        for (k = 0; k < len; k++)
        begin
            r.code = color_now ? CODE_ONE : CODE_ZERO;
            r.last = 1'b0;
            pending_pixels.push_back(r);
            if (col_now + 1 >= width)
            begin
                col_now = 0;
                r.code  = CODE_BREAK;
                pending_pixels.push_back(r);
            end
            else
                col_now++;
        end
        if (len != 0)
            pending_pixels[pending_pixels.size() - 1].last = 1'b1;
        color_now = ~color_now;
    endfunction

    // Offer one run after a random gap; returns once the transfer happens
    task automatic send_run(input logic [3:0] len);
        int gap;
        gap = tx_gap_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            run_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        run_ch.valid      <= 1'b1;
        run_ch.run_length <= len;
        @(posedge clk);
        while (!run_ch.ready)
            @(posedge clk);
        expand_run(len);
        runs_sent++;
        if (len == 0)
            zero_runs++;
    endtask

    // Mostly mid-size runs, with zero and full-length ones mixed in
    function automatic logic [3:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 4'd0;
        if (r == 1)
            return 4'd15;
        return 4'($urandom_range(1, 14));
    endfunction

    // Drop valid, let every expected result arrive, then let the block settle
    task automatic wait_idle();
        run_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic sel, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic sel, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Read a register back and compare with the shadow copy
    task automatic check_reg(input logic sel);
        logic [DATA_W-1:0] got;
        logic [DATA_W-1:0] want;
        apb_read(sel, got);
        if (sel == REG_ROW_WIDTH)
        begin
            want = DATA_W'(row_width_cfg);
            if (got !== want)
            begin
                $error("row_width: expected %0d, got %0d", want, got);
                fail_count++;
            end
        end
        else
        begin
            want = DATA_W'(start_color_cfg);
            if (got !== want)
            begin
                $error("start_color: expected %0d, got %0d", want, got);
                fail_count++;
            end
        end
    endtask

    // Register write while idle; garbage in the unused upper bits
    task automatic cfg_write(input logic sel, input int value);
        logic [DATA_W-1:0] data;
        data = ($urandom() & ~32'h1F) | DATA_W'(value);
        wait_idle();
        apb_write(sel, data);
        reg_writes++;
        if (sel == REG_ROW_WIDTH)
            row_width_cfg = data[ROW_W-1:0];
        else
        begin
            start_color_cfg = data[0];
            color_now       = data[0];
        end
        check_reg(sel);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        px_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result: out_code %0d last_of_run %0d",
                       res_ch.out_code, res_ch.last_of_run);
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                results_seen++;
                if (want.code == CODE_BREAK)
                    breaks_seen++;
                if (res_ch.out_code !== want.code)
                begin
                    $error("out_code: expected %0d, got %0d", want.code, res_ch.out_code);
                    fail_count++;
                end
                if (res_ch.last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last, res_ch.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Result receiver: random stalls, plus an optional long hold-off
    initial
    begin : res_receiver
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            stall = rx_stall_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
        end
    end

    // Watchdog: no transfer of any kind for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((run_ch.valid && run_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (psel && penable))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic test_reset_values();
        check_reg(REG_ROW_WIDTH);
        check_reg(REG_START_COLOR);
    endtask

    task automatic test_directed_runs();
        tx_gap_on   = 1'b1;
        rx_stall_on = 1'b1;
        // default width 9, color one: wrap inside a run, break as last result
        send_run(4'd15);
        send_run(4'd0);
        send_run(4'd3);
        send_run(4'd1);
        // width one: break after every pixel, longest expansion
        cfg_write(REG_ROW_WIDTH, 1);
        send_run(4'd15);
        send_run(4'd0);
        send_run(4'd0);
        // zero width acts as one
        cfg_write(REG_ROW_WIDTH, 0);
        send_run(4'd2);
        // widths above the maximum clamp to sixteen
        cfg_write(REG_ROW_WIDTH, 31);
        send_run(4'd15);
        send_run(4'd1);
        cfg_write(REG_ROW_WIDTH, 17);
        send_run(4'd4);
        cfg_write(REG_ROW_WIDTH, ROW_MAX);
        send_run(4'd10);
        // lowered below the current column: break right after next pixel
        cfg_write(REG_ROW_WIDTH, 4);
        send_run(4'd3);
        // new start color takes effect at once, column kept
        cfg_write(REG_START_COLOR, 0);
        send_run(4'd2);
        send_run(4'd5);
        cfg_write(REG_START_COLOR, 1);
        send_run(4'd1);
        send_run(4'd0);
    endtask

    task automatic test_random_phases();
        int phase;
        int n;
        int width;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       width = ROW_MIN;
                1:       width = ROW_MAX;
                2:       width = 0;
                3:       width = 31;
                default: width = $urandom_range(0, 31);
            endcase
            cfg_write(REG_ROW_WIDTH, width);
            cfg_write(REG_START_COLOR, $urandom_range(0, 1));
            tx_gap_on   = (phase != 0) && (phase != 2);
            rx_stall_on = (phase != 0) && (phase != 1);
            for (n = 0; n < 35; n++)
                send_run(pick_len());
        end
    endtask

    // Receiver holds off while runs keep coming, so the input must stall
    task automatic test_output_backpressure();
        int n;
        cfg_write(REG_ROW_WIDTH, 5);
        tx_gap_on   = 1'b0;
        rx_stall_on = 1'b0;
        hold_len    = HOLD_CYCLES;
        for (n = 0; n < 20; n++)
            send_run(n[0] ? 4'd15 : pick_len());
    endtask

    // Sender stops until the expander has fully drained, then resumes
    task automatic test_drain_pause();
        int n;
        tx_gap_on   = 1'b1;
        rx_stall_on = 1'b1;
        for (n = 0; n < 5; n++)
            send_run(pick_len());
        run_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        @(posedge clk);
        for (n = 0; n < 5; n++)
            send_run(pick_len());
    endtask

    initial
    begin
        run_ch.valid      <= 1'b0;
        run_ch.run_length <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        rst_n             <= 1'b0;
        row_width_cfg   = ROW_RST;
        start_color_cfg = COLOR_RST;
        color_now       = COLOR_RST;
        col_now         = 0;
        tx_gap_on       = 1'b0;
        rx_stall_on     = 1'b0;
        hold_len        = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_runs();
        test_random_phases();
        test_output_backpressure();
        test_drain_pause();
        wait_idle();

        $display("Sent %0d runs (%0d of zero length) through %0d register writes",
                 runs_sent, zero_runs, reg_writes);
        $display("Checked %0d results, %0d of them line breaks", results_seen, breaks_seen);
        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/rlbe_pkg.sv
rtl/rlbe_run_if.sv
rtl/rlbe_res_if.sv
rtl/rlbe_front.sv
rtl/rlbe_queue.sv
rtl/rlbe_back.sv
rtl/run_length_bitmap_expander_top.sv
test/tb_top.sv
